// ===== src/pgalloc_pkg.sv =====
`timescale 1ns / 1ps

package pgalloc_pkg;

    localparam int ADDR_W     = 40;
    localparam int CMD_W      = 2;
    localparam int STAT_W     = 2;
    localparam int CNT_OUT_W  = 8;
    localparam int FREE_W     = 16;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 64;

    localparam int NUM_PAGES_DEF  = 32768;
    localparam int PAGE_SHIFT_DEF = 12;
    localparam int COUNT_BITS_DEF = 8;

    localparam logic [ADDR_W-1:0] BASE_RST  = 40'h00_8000_0000;
    localparam logic [ADDR_W-1:0] FIRST_RST = 40'h00_8000_0000;
    localparam logic [ADDR_W-1:0] TOP_RST   = 40'h00_8800_0000;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_ADDREF = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_BADADDR = 2'd2,
        STAT_NOTPOS  = 2'd3
    } stat_t;

    typedef enum logic [1:0] {
        REG_BASE  = 2'd0,
        REG_FIRST = 2'd1,
        REG_TOP   = 2'd2
    } reg_idx_t;

    typedef enum logic [3:0] {
        SEQ_CLEAR,
        SEQ_IDLE,
        SEQ_POP,
        SEQ_POP_WAIT,
        SEQ_ADDR,
        SEQ_CHK_BASE,
        SEQ_CHK_TOP,
        SEQ_CHK_FIRST,
        SEQ_UPDATE,
        SEQ_DONE
    } seq_state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] region_base;
        logic [ADDR_W-1:0] first_usable;
        logic [ADDR_W-1:0] region_top;
    } cfg_t;

endpackage

// ===== src/pgalloc_ram.sv =====
`timescale 1ns / 1ps

module pgalloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/pgalloc_alu.sv =====
`timescale 1ns / 1ps

module pgalloc_alu (
    input  logic [pgalloc_pkg::ADDR_W-1:0] a,
    input  logic [pgalloc_pkg::ADDR_W-1:0] b,
    input  logic                           sub,
    output logic [pgalloc_pkg::ADDR_W-1:0] sum,
    output logic                           borrow
);

    import pgalloc_pkg::*;

    logic [ADDR_W:0] full;

    // A subtraction adds the inverted operand plus one; the carry out is set when a >= b.
    assign full   = {1'b0, a} + {1'b0, b ^ {ADDR_W{sub}}} + {{ADDR_W{1'b0}}, sub};
    assign sum    = full[ADDR_W-1:0];
    assign borrow = sub & ~full[ADDR_W];

endmodule

// ===== src/pgalloc_cfg.sv =====
`timescale 1ns / 1ps

module pgalloc_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pgalloc_pkg::PADDR_W-1:0] paddr,
    input  logic [pgalloc_pkg::PDATA_W-1:0] pwdata,
    output logic [pgalloc_pkg::PDATA_W-1:0] prdata,
    output logic                            pready,
    output pgalloc_pkg::cfg_t               cfg
);

    import pgalloc_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[4:3]);
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_BASE:  cfg_next.region_base  = pwdata[ADDR_W-1:0];
                REG_FIRST: cfg_next.first_usable = pwdata[ADDR_W-1:0];
                REG_TOP:   cfg_next.region_top   = pwdata[ADDR_W-1:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_BASE:  prdata = PDATA_W'(cfg_reg.region_base);
            REG_FIRST: prdata = PDATA_W'(cfg_reg.first_usable);
            REG_TOP:   prdata = PDATA_W'(cfg_reg.region_top);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.region_base  <= BASE_RST;
            cfg_reg.first_usable <= FIRST_RST;
            cfg_reg.region_top   <= TOP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/page_allocator_with_refcounts_top.sv =====
`timescale 1ns / 1ps

// Page allocator with a LIFO free-page stack and a reference count per page.
// A request carries cmd (alloc, free, add reference, read count) and page_addr; it is
// taken at a clock edge where in_valid is high and in_stall is low. Each request gives
// exactly one response on the out_valid / out_stall channel, in request order.
// The block handles one request at a time. An alloc pops the free stack, writes a
// count of one for the popped page and forms the page address; an alloc on an empty
// stack goes straight to its response. Free, add reference and read count check the
// address against the base and top bounds (a free also against the first usable
// address), then read and update the count; a rejected address skips the update.
// The sequencer passes through the idle state before the next request is taken. One
// 40-bit add/subtract unit checks the bounds in turn and forms the allocated address.
// The response sits in an output register; while out_stall is high it holds, and a
// finished request waits in the sequencer until the register is free. A new request
// can be taken while a response still waits to be taken.
// After reset every count is written to one by a clearing pass over all NUM_PAGES
// entries, during which in_stall stays high; the stack is empty and the bounds
// registers hold their defaults. The APB port writes the bounds at any time, but
// only while the block is idle does a write have a defined effect on requests.
module page_allocator_with_refcounts_top #(
    parameter int NUM_PAGES  = pgalloc_pkg::NUM_PAGES_DEF,
    parameter int PAGE_SHIFT = pgalloc_pkg::PAGE_SHIFT_DEF,
    parameter int COUNT_BITS = pgalloc_pkg::COUNT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pgalloc_pkg::PADDR_W-1:0]   paddr,
    input  logic [pgalloc_pkg::PDATA_W-1:0]   pwdata,
    output logic [pgalloc_pkg::PDATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [pgalloc_pkg::CMD_W-1:0]     cmd,
    input  logic [pgalloc_pkg::ADDR_W-1:0]    page_addr,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [pgalloc_pkg::STAT_W-1:0]    status,
    output logic [pgalloc_pkg::ADDR_W-1:0]    result_addr,
    output logic [pgalloc_pkg::CNT_OUT_W-1:0] ref_count,
    output logic                              page_released,
    output logic [pgalloc_pkg::FREE_W-1:0]    free_pages
);

    import pgalloc_pkg::*;

    localparam int IDX_W   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
    localparam int SLOT_W  = ADDR_W - PAGE_SHIFT;
    localparam int CMP_W   = ADDR_W + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
    localparam logic [IDX_W-1:0]      LAST_CLR  = IDX_W'(NUM_PAGES - 1);
    localparam logic [DEPTH_W-1:0]    DEPTH_MAX = DEPTH_W'(NUM_PAGES);

    cfg_t cfg;

    seq_state_t state_reg;
    seq_state_t state_next;

    cmd_t                   cmd_reg;
    logic [ADDR_W-1:0]      pa_reg;
    logic                   bad_reg;
    logic [IDX_W-1:0]       slot_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       clr_reg;
    logic [DEPTH_W-1:0]     depth_reg;

    stat_t                  res_status_reg;
    logic [ADDR_W-1:0]      res_addr_reg;
    logic [COUNT_BITS-1:0]  res_count_reg;
    logic                   res_rel_reg;

    logic                   out_valid_reg;
    stat_t                  out_status_reg;
    logic [ADDR_W-1:0]      out_addr_reg;
    logic [CNT_OUT_W-1:0]   out_count_reg;
    logic                   out_rel_reg;
    logic [FREE_W-1:0]      out_free_reg;

    logic [ADDR_W-1:0]      alu_a;
    logic [ADDR_W-1:0]      alu_b;
    logic                   alu_sub;
    logic [ADDR_W-1:0]      alu_sum;
    logic                   alu_borrow;

    logic                   ref_we;
    logic [IDX_W-1:0]       ref_waddr;
    logic [COUNT_BITS-1:0]  ref_wdata;
    logic                   ref_re;
    logic [COUNT_BITS-1:0]  ref_rdata;

    logic                   stk_we;
    logic [IDX_W-1:0]       stk_waddr;
    logic                   stk_re;
    logic [IDX_W-1:0]       stk_raddr;
    logic [IDX_W-1:0]       stk_rdata;

    logic [COUNT_BITS-1:0]  upd_count;
    logic                   upd_write;
    logic                   count_zero;
    logic                   push_ok;
    logic                   bad_now;
    logic                   misaligned;
    logic [SLOT_W-1:0]      slot_full;
    logic                   slot_ok;
    logic [IDX_W+PAGE_SHIFT-1:0] idx_addr;
    logic                   accept;
    logic                   out_load;

    pgalloc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pgalloc_alu u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .sub    (alu_sub),
        .sum    (alu_sum),
        .borrow (alu_borrow)
    );

    pgalloc_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_PAGES)
    ) u_count_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (ref_waddr),
        .wdata (ref_wdata),
        .re    (ref_re),
        .raddr (slot_reg),
        .rdata (ref_rdata)
    );

    pgalloc_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_PAGES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (slot_reg),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign in_stall = (state_reg != SEQ_IDLE);
    assign accept   = in_valid & ~in_stall;
    assign out_load = (state_reg == SEQ_DONE) & (~out_valid_reg | ~out_stall);

    assign misaligned = (pa_reg[PAGE_SHIFT-1:0] != '0);
    assign slot_full  = alu_sum[ADDR_W-1:PAGE_SHIFT];
    assign slot_ok    = (CMP_W'(slot_full) < CMP_W'(NUM_PAGES));
    assign idx_addr   = {idx_reg, {PAGE_SHIFT{1'b0}}};
    assign bad_now    = bad_reg | (alu_borrow & (cmd_reg == CMD_FREE));
    assign stk_raddr  = IDX_W'(depth_reg - 1'b1);
    assign stk_waddr  = IDX_W'(depth_reg);
    assign count_zero = (ref_rdata == '0);

    always_comb
    begin
        unique case (cmd_reg)
            CMD_FREE:
            begin
                upd_count = ref_rdata - 1'b1;
                upd_write = ~count_zero;
            end
            CMD_ADDREF:
            begin
                upd_count = (ref_rdata == COUNT_MAX) ? ref_rdata : ref_rdata + 1'b1;
                upd_write = 1'b1;
            end
            default:
            begin
                upd_count = ref_rdata;
                upd_write = 1'b0;
            end
        endcase
    end

    assign push_ok = (cmd_reg == CMD_FREE) & (ref_rdata == COUNT_ONE) & (depth_reg < DEPTH_MAX);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_CLEAR:
            begin
                if (clr_reg == LAST_CLR)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            SEQ_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (cmd_t'(cmd) == CMD_ALLOC) ? SEQ_POP : SEQ_CHK_BASE;
                end
            end
            SEQ_POP:       state_next = (depth_reg == '0) ? SEQ_DONE : SEQ_POP_WAIT;
            SEQ_POP_WAIT:  state_next = SEQ_ADDR;
            SEQ_ADDR:      state_next = SEQ_DONE;
            SEQ_CHK_BASE:  state_next = SEQ_CHK_TOP;
            SEQ_CHK_TOP:   state_next = SEQ_CHK_FIRST;
            SEQ_CHK_FIRST: state_next = bad_now ? SEQ_DONE : SEQ_UPDATE;
            SEQ_UPDATE:    state_next = SEQ_DONE;
            SEQ_DONE:
            begin
                if (out_load)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:       state_next = SEQ_IDLE;
        endcase
    end

    always_comb
    begin
        alu_a     = pa_reg;
        alu_b     = cfg.region_base;
        alu_sub   = 1'b1;
        ref_we    = 1'b0;
        ref_waddr = slot_reg;
        ref_wdata = upd_count;
        ref_re    = 1'b0;
        stk_we    = 1'b0;
        stk_re    = 1'b0;
        unique case (state_reg)
            SEQ_CLEAR:
            begin
                ref_we    = 1'b1;
                ref_waddr = clr_reg;
                ref_wdata = COUNT_ONE;
            end
            SEQ_POP:
            begin
                stk_re = (depth_reg != '0);
            end
            SEQ_POP_WAIT:
            begin
                ref_we    = 1'b1;
                ref_waddr = stk_rdata;
                ref_wdata = COUNT_ONE;
            end
            SEQ_ADDR:
            begin
                alu_a   = cfg.region_base;
                alu_b   = ADDR_W'(idx_addr);
                alu_sub = 1'b0;
            end
            SEQ_CHK_BASE:
            begin
                alu_b = cfg.region_base;
            end
            SEQ_CHK_TOP:
            begin
                alu_b = cfg.region_top;
            end
            SEQ_CHK_FIRST:
            begin
                alu_b  = cfg.first_usable;
                ref_re = 1'b1;
            end
            SEQ_UPDATE:
            begin
                ref_we = upd_write;
                stk_we = push_ok;
            end
            default:
            begin
                alu_sub = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_CLEAR;
            clr_reg       <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == SEQ_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if ((state_reg == SEQ_POP) && (depth_reg != '0))
            begin
                depth_reg <= depth_reg - 1'b1;
            end
            else if ((state_reg == SEQ_UPDATE) && push_ok)
            begin
                depth_reg <= depth_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_t'(cmd);
            pa_reg  <= page_addr;
        end
        unique case (state_reg)
            SEQ_POP:
            begin
                res_status_reg <= STAT_EMPTY;
                res_addr_reg   <= '0;
                res_count_reg  <= '0;
                res_rel_reg    <= 1'b0;
            end
            SEQ_POP_WAIT:
            begin
                idx_reg <= stk_rdata;
            end
            SEQ_ADDR:
            begin
                res_status_reg <= STAT_OK;
                res_addr_reg   <= alu_sum;
                res_count_reg  <= COUNT_ONE;
                res_rel_reg    <= 1'b0;
            end
            SEQ_CHK_BASE:
            begin
                bad_reg  <= alu_borrow | misaligned | ~slot_ok;
                slot_reg <= IDX_W'(slot_full);
            end
            SEQ_CHK_TOP:
            begin
                bad_reg <= bad_reg | ~alu_borrow;
            end
            SEQ_CHK_FIRST:
            begin
                res_status_reg <= STAT_BADADDR;
                res_addr_reg   <= pa_reg;
                res_count_reg  <= '0;
                res_rel_reg    <= 1'b0;
            end
            SEQ_UPDATE:
            begin
                res_addr_reg <= pa_reg;
                res_rel_reg  <= push_ok;
                if ((cmd_reg == CMD_FREE) && count_zero)
                begin
                    res_status_reg <= STAT_NOTPOS;
                    res_count_reg  <= '0;
                end
                else
                begin
                    res_status_reg <= STAT_OK;
                    res_count_reg  <= upd_count;
                end
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= res_addr_reg;
            out_count_reg  <= CNT_OUT_W'(res_count_reg);
            out_rel_reg    <= res_rel_reg;
            out_free_reg   <= FREE_W'(depth_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign result_addr   = out_addr_reg;
    assign ref_count     = out_count_reg;
    assign page_released = out_rel_reg;
    assign free_pages    = out_free_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == SEQ_POP || state_reg == SEQ_CHK_BASE))
        else $error("An accepted request did not start a command sequence.");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_MAX)
        else $error("The free stack depth exceeds the page count.");

    a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_POP && depth_reg != '0) |=> depth_reg == $past(depth_reg) - 1'b1)
        else $error("A pop did not lower the stack depth by one.");

    a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_UPDATE && stk_we) |=> depth_reg == $past(depth_reg) + 1'b1)
        else $error("A push did not raise the stack depth by one.");

    a_release_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_rel_reg) |-> (out_status_reg == STAT_OK && out_count_reg == '0))
        else $error("A released page reports a nonzero count or a failure.");

endmodule

// ===== sim/pgalloc_checker.sv =====
`timescale 1ns / 1ps

module pgalloc_checker
    import pgalloc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    input  logic [PDATA_W-1:0]     prdata,
    input  logic                   pready,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [CMD_W-1:0]       cmd,
    input  logic [ADDR_W-1:0]      page_addr,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [STAT_W-1:0]      status,
    input  logic [ADDR_W-1:0]      result_addr,
    input  logic [CNT_OUT_W-1:0]   ref_count,
    input  logic                   page_released,
    input  logic [FREE_W-1:0]      free_pages,
    output int unsigned            mismatches,
    output int unsigned            outstanding,
    output int unsigned            n_checked,
    output int unsigned            n_released,
    output int unsigned            n_empty,
    output int unsigned            n_badaddr,
    output int unsigned            n_notpos
);

    localparam int IDX_W = $clog2(NUM_PAGES_DEF);
    localparam logic [COUNT_BITS_DEF-1:0] COUNT_MAX = '1;

    typedef struct packed {
        stat_t                 status;
        logic [ADDR_W-1:0]     addr;
        logic [CNT_OUT_W-1:0]  count;
        logic                  released;
        logic [FREE_W-1:0]     depth;
    } page_resp_t;

    page_resp_t                responses_due[$];
    logic [ADDR_W-1:0]         base_addr;
    logic [ADDR_W-1:0]         free_floor;
    logic [ADDR_W-1:0]         top_addr;
    logic [IDX_W-1:0]          stacked_pages [NUM_PAGES_DEF];
    logic [IDX_W:0]            stack_level;
    logic [COUNT_BITS_DEF-1:0] page_refs [NUM_PAGES_DEF];

    task automatic compare_field(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    // Applies one request to the allocator state and returns the response it owes.
    function automatic page_resp_t apply_page_cmd(cmd_t op, logic [ADDR_W-1:0] pa);
        page_resp_t        r;
        logic [ADDR_W-1:0] slot;
        logic [IDX_W-1:0]  idx;
        logic              good;
        r.status   = STAT_OK;
        r.addr     = pa;
        r.count    = '0;
        r.released = 1'b0;
        if (op == CMD_ALLOC)
        begin
            if (stack_level == 0)
            begin
                r.status = STAT_EMPTY;
                r.addr   = '0;
            end
            else
            begin
                stack_level = stack_level - 1'b1;
                idx = stacked_pages[stack_level[IDX_W-1:0]];
                page_refs[idx] = COUNT_BITS_DEF'(1);
                r.count = CNT_OUT_W'(1);
                r.addr = base_addr + (ADDR_W'(idx) << PAGE_SHIFT_DEF);
            end
        end
        else
        begin
            slot = (pa - base_addr) >> PAGE_SHIFT_DEF;
            good = (pa[PAGE_SHIFT_DEF-1:0] == '0) && (pa >= base_addr) && (pa < top_addr)
                && !(op == CMD_FREE && pa < free_floor) && (slot < NUM_PAGES_DEF);
            idx = slot[IDX_W-1:0];
            if (!good)
            begin
                r.status = STAT_BADADDR;
            end
            else if (op == CMD_FREE)
            begin
                if (page_refs[idx] == 0)
                begin
                    r.status = STAT_NOTPOS;
                end
                else
                begin
                    page_refs[idx] = page_refs[idx] - 1'b1;
                    r.count = CNT_OUT_W'(page_refs[idx]);
                    if (page_refs[idx] == 0 && stack_level < NUM_PAGES_DEF)
                    begin
                        stacked_pages[stack_level[IDX_W-1:0]] = idx;
                        stack_level = stack_level + 1'b1;
                        r.released = 1'b1;
                    end
                end
            end
            else if (op == CMD_ADDREF)
            begin
                if (page_refs[idx] != COUNT_MAX)
                begin
                    page_refs[idx] = page_refs[idx] + 1'b1;
                end
                r.count = CNT_OUT_W'(page_refs[idx]);
            end
            else
            begin
                r.count = CNT_OUT_W'(page_refs[idx]);
            end
        end
        r.depth = FREE_W'(stack_level);
        return r;
    endfunction

    always @(posedge clk)
    begin
        page_resp_t want;
        if (!rst_n)
        begin
            base_addr   = BASE_RST;
            free_floor  = FIRST_RST;
            top_addr    = TOP_RST;
            stack_level = '0;
            for (int i = 0; i < NUM_PAGES_DEF; i++)
            begin
                page_refs[i] = COUNT_BITS_DEF'(1);
            end
            responses_due.delete();
            mismatches = 0;
            n_checked  = 0;
            n_released = 0;
            n_empty    = 0;
            n_badaddr  = 0;
            n_notpos   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                n_checked++;
                if (responses_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: response with no request outstanding, expected none, actual %0h",
                             $time, result_addr);
                end
                else
                begin
                    want = responses_due.pop_front();
                    compare_field("status", 64'(want.status), 64'(status));
                    compare_field("result_addr", 64'(want.addr), 64'(result_addr));
                    compare_field("ref_count", 64'(want.count), 64'(ref_count));
                    compare_field("page_released", 64'(want.released), 64'(page_released));
                    compare_field("free_pages", 64'(want.depth), 64'(free_pages));
                end
            end
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[PADDR_W-1:3])
                        REG_BASE:  base_addr  = pwdata[ADDR_W-1:0];
                        REG_FIRST: free_floor = pwdata[ADDR_W-1:0];
                        REG_TOP:   top_addr   = pwdata[ADDR_W-1:0];
                        default: ;
                    endcase
                end
                else
                begin
                    case (paddr[PADDR_W-1:3])
                        REG_BASE:  compare_field("region_base read", 64'(base_addr), prdata);
                        REG_FIRST: compare_field("first_usable read", 64'(free_floor), prdata);
                        REG_TOP:   compare_field("region_top read", 64'(top_addr), prdata);
                        default: ;
                    endcase
                end
            end
            if (in_valid && !in_stall)
            begin
                want = apply_page_cmd(cmd_t'(cmd), page_addr);
                responses_due.push_back(want);
                n_released += want.released;
                if (want.status == STAT_EMPTY)
                begin
                    n_empty++;
                end
                if (want.status == STAT_BADADDR)
                begin
                    n_badaddr++;
                end
                if (want.status == STAT_NOTPOS)
                begin
                    n_notpos++;
                end
            end
        end
        outstanding = responses_due.size();
    end

endmodule

// ===== sim/page_allocator_with_refcounts_top_tb.sv =====
`timescale 1ns / 1ps

module page_allocator_with_refcounts_top_tb;
    import pgalloc_pkg::*;

    localparam int CYCLE_LIMIT     = 3_000_000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int TAIL_CYCLES     = 20;
    localparam int FILL_PAGES      = 16;
    localparam int NPAGES          = NUM_PAGES_DEF;
    localparam int PAGE_OFS_MAX    = (1 << PAGE_SHIFT_DEF) - 1;
    localparam logic [ADDR_W-1:0] PAGE_BYTES = ADDR_W'(1) << PAGE_SHIFT_DEF;
    localparam logic [ADDR_W-1:0] ADDR_MAX   = '1;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 in_valid;
    logic                 in_stall;
    logic [CMD_W-1:0]     cmd;
    logic [ADDR_W-1:0]    page_addr;
    logic                 out_valid;
    logic                 out_stall;
    logic [STAT_W-1:0]    status;
    logic [ADDR_W-1:0]    result_addr;
    logic [CNT_OUT_W-1:0] ref_count;
    logic                 page_released;
    logic [FREE_W-1:0]    free_pages;

    int unsigned          mismatches;
    int unsigned          outstanding;
    int unsigned          n_checked;
    int unsigned          n_released;
    int unsigned          n_empty;
    int unsigned          n_badaddr;
    int unsigned          n_notpos;

    int unsigned          cycles = 0;
    bit                   tx_idle_en;
    bit                   rx_idle_en;
    int unsigned          hold_off_reqs = 0;
    logic [ADDR_W-1:0]    cur_base;
    logic [ADDR_W-1:0]    cur_first;
    logic [ADDR_W-1:0]    cur_top;

    page_allocator_with_refcounts_top DUT (.*);

    pgalloc_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // The result side stalls in short random bursts, or for one long stretch on request.
    initial
    begin
        int unsigned hold_off_done;
        hold_off_done = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_reqs != hold_off_done)
            begin
                hold_off_done++;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_req(input cmd_t op, input logic [ADDR_W-1:0] pa);
        int unsigned gap;
        in_valid  <= 1'b1;
        cmd       <= op;
        page_addr <= pa;
        do @(posedge clk); while (in_stall);
        gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        @(posedge clk);
    endtask

    task automatic apb_access(input reg_idx_t r, input logic wr, input logic [ADDR_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {r, 3'b000};
        pwdata  <= {24'($urandom), v};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_bounds(input logic [ADDR_W-1:0] b, input logic [ADDR_W-1:0] f,
                              input logic [ADDR_W-1:0] t);
        drain;
        cur_base  = b;
        cur_first = f;
        cur_top   = t;
        apb_access(REG_BASE, 1'b1, b);
        apb_access(REG_FIRST, 1'b1, f);
        apb_access(REG_TOP, 1'b1, t);
        apb_access(REG_BASE, 1'b0, '0);
        apb_access(REG_FIRST, 1'b0, '0);
        apb_access(REG_TOP, 1'b0, '0);
    endtask

    // Most requests hit a few hot pages so that counts and the stack move deeply.
    task automatic send_random_req;
        cmd_t              op;
        logic [ADDR_W-1:0] pa;
        logic [ADDR_W-1:0] hot;
        int unsigned       pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            op = CMD_ALLOC;
        end
        else if (pick < 55)
        begin
            op = CMD_FREE;
        end
        else if (pick < 80)
        begin
            op = CMD_ADDREF;
        end
        else
        begin
            op = CMD_READ;
        end
        hot = (($urandom_range(0, 1) != 0) ? cur_first : cur_base) + PAGE_BYTES - 1'b1;
        hot = hot & ~(PAGE_BYTES - 1'b1);
        if ($urandom_range(0, 7) == 0)
        begin
            hot = hot + (ADDR_W'($urandom_range(0, NPAGES - 1)) << PAGE_SHIFT_DEF);
        end
        else
        begin
            hot = hot + (ADDR_W'($urandom_range(0, 11)) << PAGE_SHIFT_DEF);
        end
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            pa = hot;
        end
        else if (pick < 80)
        begin
            case ($urandom_range(0, 5))
                0: pa = cur_base - PAGE_BYTES;
                1: pa = cur_first - PAGE_BYTES;
                2: pa = cur_top - PAGE_BYTES;
                3: pa = cur_top;
                4: pa = cur_base + (ADDR_W'(NPAGES) << PAGE_SHIFT_DEF);
                default: pa = cur_first;
            endcase
        end
        else if (pick < 90)
        begin
            pa = hot | ADDR_W'($urandom_range(1, PAGE_OFS_MAX));
        end
        else
        begin
            pa = {8'($urandom), 32'($urandom)};
        end
        send_req(op, pa);
    endtask

    initial
    begin
        logic [ADDR_W-1:0] b;
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        in_valid  <= 1'b0;
        cmd       <= CMD_ALLOC;
        page_addr <= '0;
        tx_idle_en   = 1'b0;
        rx_idle_en   = 1'b0;
        cur_base  = BASE_RST;
        cur_first = FIRST_RST;
        cur_top   = TOP_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Free a run of pages, stack the first one twice, then pop the stack empty.
        for (int i = 0; i < FILL_PAGES; i++)
        begin
            send_req(CMD_FREE, cur_base + (ADDR_W'(i) << PAGE_SHIFT_DEF));
        end
        send_req(CMD_ADDREF, cur_base);
        send_req(CMD_FREE, cur_base);
        send_req(CMD_READ, cur_base);
        for (int i = 0; i < FILL_PAGES + 2; i++)
        begin
            send_req(CMD_ALLOC, {8'($urandom), 32'($urandom)});
        end
        send_req(CMD_ALLOC, ADDR_MAX);

        send_req(CMD_FREE, cur_base);
        send_req(CMD_FREE, cur_base);
        send_req(CMD_READ, cur_base);
        send_req(CMD_ALLOC, '0);
        send_req(CMD_ADDREF, cur_base);
        send_req(CMD_FREE, cur_base);
        send_req(CMD_FREE, cur_base);
        send_req(CMD_ADDREF, cur_base);
        send_req(CMD_FREE, cur_base);
        send_req(CMD_ALLOC, '0);
        send_req(CMD_ALLOC, '0);
        send_req(CMD_FREE, cur_base + 1'b1);
        send_req(CMD_FREE, cur_base - PAGE_BYTES);
        send_req(CMD_READ, cur_top);
        send_req(CMD_READ, cur_top - PAGE_BYTES);
        send_req(CMD_ADDREF, ADDR_MAX);
        send_req(CMD_READ, '0);
        send_req(CMD_ADDREF, ADDR_MAX & ~(PAGE_BYTES - 1'b1));
        repeat (256) send_req(CMD_ADDREF, cur_base + PAGE_BYTES);
        send_req(CMD_READ, cur_base + PAGE_BYTES);
        send_req(CMD_FREE, cur_base + PAGE_BYTES);

        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (40) send_random_req;
        hold_off_reqs++;
        repeat (20) send_random_req;
        repeat (40) send_random_req;

        set_bounds('0, 40'h00_0001_0000, 40'h00_0800_0000);
        repeat (40) send_random_req;
        drain;
        repeat (40) send_random_req;

        set_bounds(40'h00_0000_0800, '0, 40'h00_0100_0000);
        repeat (40) send_random_req;

        set_bounds(ADDR_MAX & ~(PAGE_BYTES - 1'b1), ADDR_MAX & ~(PAGE_BYTES - 1'b1), ADDR_MAX);
        repeat (40) send_random_req;

        set_bounds('0, ADDR_MAX, '0);
        repeat (20) send_random_req;

        set_bounds('0, ADDR_MAX, ADDR_MAX);
        repeat (20) send_random_req;

        for (int k = 0; k < 3; k++)
        begin
            if (k == 2)
            begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            b = {8'($urandom), 20'($urandom), 12'h000};
            set_bounds(b, b + (ADDR_W'($urandom_range(0, 8)) << PAGE_SHIFT_DEF),
                       b + (ADDR_W'($urandom_range(1, 40000)) << PAGE_SHIFT_DEF));
            repeat (30) send_random_req;
        end

        drain;
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Checked %0d responses over nine bound settings and a saturated count.",
                 n_checked);
        $display("Seen %0d page releases, %0d empty allocs, %0d bad addresses, %0d zero-count frees.",
                 n_released, n_empty, n_badaddr, n_notpos);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
